/* rtl/rvcd_pkg.sv */
package rvcd_pkg;

  // Major opcodes.
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
  localparam logic [6:0] OPC_OPIMM  = 7'b0010011;
  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP32   = 7'b0111011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_FLOAD  = 7'b0000111;
  localparam logic [6:0] OPC_FSTORE = 7'b0100111;
  localparam logic [6:0] OPC_FMADD  = 7'b1000011;
  localparam logic [6:0] OPC_FMSUB  = 7'b1000111;
  localparam logic [6:0] OPC_FNMSUB = 7'b1001011;
  localparam logic [6:0] OPC_FNMADD = 7'b1001111;
  localparam logic [6:0] OPC_OPFP   = 7'b1010011;

  // funct7 codes of the integer register-register group.
  localparam logic [6:0] F7_MULDIV = 7'b0000001;

  // funct7 codes of OP-FP.
  localparam logic [6:0] F7_FADD_S   = 7'h00;
  localparam logic [6:0] F7_FADD_D   = 7'h01;
  localparam logic [6:0] F7_FSUB_S   = 7'h04;
  localparam logic [6:0] F7_FSUB_D   = 7'h05;
  localparam logic [6:0] F7_FMUL_S   = 7'h08;
  localparam logic [6:0] F7_FMUL_D   = 7'h09;
  localparam logic [6:0] F7_FDIV_S   = 7'h0C;
  localparam logic [6:0] F7_FDIV_D   = 7'h0D;
  localparam logic [6:0] F7_FSQRT_S  = 7'h2C;
  localparam logic [6:0] F7_FSQRT_D  = 7'h2D;
  localparam logic [6:0] F7_FCVT_IS  = 7'h60;
  localparam logic [6:0] F7_FCVT_ID  = 7'h61;
  localparam logic [6:0] F7_FCVT_SI  = 7'h68;
  localparam logic [6:0] F7_FCVT_DI  = 7'h69;
  localparam logic [6:0] F7_FSGNJ_S  = 7'h10;
  localparam logic [6:0] F7_FSGNJ_D  = 7'h11;
  localparam logic [6:0] F7_FMINMAX_S = 7'h14;
  localparam logic [6:0] F7_FMINMAX_D = 7'h15;
  localparam logic [6:0] F7_FCMP_S   = 7'h50;
  localparam logic [6:0] F7_FCMP_D   = 7'h51;
  localparam logic [6:0] F7_FMV_WX   = 7'h78;
  localparam logic [6:0] F7_FMV_DX   = 7'h79;
  localparam logic [6:0] F7_FMV_XW   = 7'h70;
  localparam logic [6:0] F7_FMV_XD   = 7'h71;
  localparam logic [6:0] F7_FCVT_DS  = 7'h21;
  localparam logic [6:0] F7_FCVT_SD  = 7'h20;

  // funct3 codes used by name.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  localparam logic [2:0] F3_FLE  = 3'd0;
  localparam logic [2:0] F3_FLT  = 3'd1;
  localparam logic [2:0] F3_FEQ  = 3'd2;
  localparam logic [2:0] F3_FMV  = 3'd0;
  localparam logic [2:0] F3_FCLASS = 3'd1;

  localparam logic [4:0] RS2_FROM_S = 5'd0;
  localparam logic [4:0] RS2_FROM_D = 5'd1;

  // ALU classes.
  localparam logic [1:0] CLASS_ADD    = 2'd0;
  localparam logic [1:0] CLASS_BRANCH = 2'd1;
  localparam logic [1:0] CLASS_REG    = 2'd2;

  // ALU operation codes. Groups that the decoder indexes are given by their first member.
  localparam logic [6:0] OP_NONE    = 7'd0;
  localparam logic [6:0] OP_ADD     = 7'd1;
  localparam logic [6:0] OP_SUB     = 7'd2;
  localparam logic [6:0] OP_SLL     = 7'd3;
  localparam logic [6:0] OP_SLT     = 7'd4;
  localparam logic [6:0] OP_SLTU    = 7'd5;
  localparam logic [6:0] OP_XOR     = 7'd6;
  localparam logic [6:0] OP_SRL     = 7'd7;
  localparam logic [6:0] OP_SRA     = 7'd8;
  localparam logic [6:0] OP_OR      = 7'd9;
  localparam logic [6:0] OP_AND     = 7'd10;
  localparam logic [6:0] OP_MUL     = 7'd11;
  localparam logic [6:0] OP_ADDW    = 7'd19;
  localparam logic [6:0] OP_SLLW    = 7'd20;
  localparam logic [6:0] OP_SRLW    = 7'd21;
  localparam logic [6:0] OP_SRAW    = 7'd22;
  localparam logic [6:0] OP_MULW    = 7'd23;
  localparam logic [6:0] OP_DIVW    = 7'd24;
  localparam logic [6:0] OP_DIVUW   = 7'd25;
  localparam logic [6:0] OP_REMW    = 7'd26;
  localparam logic [6:0] OP_REMUW   = 7'd27;
  localparam logic [6:0] OP_FMADD_S = 7'd28;
  localparam logic [6:0] OP_FADD_S  = 7'd36;
  localparam logic [6:0] OP_FADD_D  = 7'd37;
  localparam logic [6:0] OP_FSUB_S  = 7'd38;
  localparam logic [6:0] OP_FSUB_D  = 7'd39;
  localparam logic [6:0] OP_FMUL_S  = 7'd40;
  localparam logic [6:0] OP_FMUL_D  = 7'd41;
  localparam logic [6:0] OP_FDIV_S  = 7'd42;
  localparam logic [6:0] OP_FDIV_D  = 7'd43;
  localparam logic [6:0] OP_FSQRT_S = 7'd44;
  localparam logic [6:0] OP_FSQRT_D = 7'd45;
  localparam logic [6:0] OP_FCVT_W_S = 7'd46;
  localparam logic [6:0] OP_FCVT_W_D = 7'd50;
  localparam logic [6:0] OP_FCVT_S_W = 7'd54;
  localparam logic [6:0] OP_FCVT_D_W = 7'd58;
  localparam logic [6:0] OP_FCVT_S_D = 7'd62;
  localparam logic [6:0] OP_FCVT_D_S = 7'd63;
  localparam logic [6:0] OP_FSGNJ_S = 7'd64;
  localparam logic [6:0] OP_FSGNJ_D = 7'd67;
  localparam logic [6:0] OP_FMIN_S  = 7'd70;
  localparam logic [6:0] OP_FMIN_D  = 7'd72;
  localparam logic [6:0] OP_FEQ_S   = 7'd74;
  localparam logic [6:0] OP_FLT_S   = 7'd75;
  localparam logic [6:0] OP_FLE_S   = 7'd76;
  localparam logic [6:0] OP_FEQ_D   = 7'd77;
  localparam logic [6:0] OP_FLT_D   = 7'd78;
  localparam logic [6:0] OP_FLE_D   = 7'd79;
  localparam logic [6:0] OP_FMV_W_X = 7'd80;
  localparam logic [6:0] OP_FMV_D_X = 7'd81;
  localparam logic [6:0] OP_FMV_X_W = 7'd82;
  localparam logic [6:0] OP_FMV_X_D = 7'd83;
  localparam logic [6:0] OP_FCLASS_S = 7'd84;
  localparam logic [6:0] OP_FCLASS_D = 7'd85;

  typedef struct packed {
    logic       reg_write;
    logic       mem_to_reg;
    logic       is_branch;
    logic       mem_read;
    logic       mem_write;
    logic       alu_imm_src;
    logic       is_jump;
    logic       pc_operand;
    logic [1:0] alu_class;
    logic [6:0] alu_operation;
  } ctrl_t;

endpackage

/* rtl/rvcd_decode.sv */
module rvcd_decode
  import rvcd_pkg::*;
(
  input  logic [31:0] instruction_i,
  output ctrl_t       ctrl_o
);

  logic [6:0] opc;
  logic [2:0] f3;
  logic [6:0] f7;
  logic [4:0] rs2;
  logic       alt;
  logic       word;

  assign opc  = instruction_i[6:0];
  assign f3   = instruction_i[14:12];
  assign f7   = instruction_i[31:25];
  assign rs2  = instruction_i[24:20];
  assign alt  = |instruction_i[31:30];
  assign word = (opc == OPC_OP32);

  // Basic integer operation selected by funct3 alone.
  function automatic logic [6:0] int_op(input logic [2:0] sel);
    logic [6:0] res;
    unique case (sel)
      F3_ADD:  res = OP_ADD;
      F3_SLL:  res = OP_SLL;
      F3_SLT:  res = OP_SLT;
      F3_SLTU: res = OP_SLTU;
      F3_XOR:  res = OP_XOR;
      F3_SRL:  res = OP_SRL;
      F3_OR:   res = OP_OR;
      F3_AND:  res = OP_AND;
      default: res = OP_NONE;
    endcase
    return res;
  endfunction

  logic [6:0] reg_op;
  logic [6:0] fp_op;
  logic [6:0] fma_op;

  always_comb begin
    if (f7 == F7_MULDIV) begin
      if (word) begin
        unique case (f3)
          F3_ADD:  reg_op = OP_MULW;
          F3_XOR:  reg_op = OP_DIVW;
          F3_SRL:  reg_op = OP_DIVUW;
          F3_OR:   reg_op = OP_REMW;
          F3_AND:  reg_op = OP_REMUW;
          default: reg_op = OP_NONE;
        endcase
      end else begin
        reg_op = OP_MUL + {4'd0, f3};
      end
    end else begin
      unique case (f3)
        F3_ADD:  reg_op = alt ? OP_SUB : (word ? OP_ADDW : OP_ADD);
        F3_SLL:  reg_op = word ? OP_SLLW : OP_SLL;
        F3_SRL: begin
          if (word) reg_op = alt ? OP_SRAW : OP_SRLW;
          else      reg_op = alt ? OP_SRA : OP_SRL;
        end
        default: reg_op = int_op(f3);
      endcase
    end
  end

  // Fused multiply-add: opcode bits 3:2 pick the variant, fmt picks the precision.
  always_comb begin
    if (!instruction_i[26]) begin
      fma_op = OP_FMADD_S + {4'd0, opc[3:2], 1'b0} + {6'd0, instruction_i[25]};
    end else begin
      fma_op = OP_ADD;
    end
  end

  always_comb begin
    fp_op = OP_NONE;
    unique case (f7)
      F7_FADD_S:  fp_op = OP_FADD_S;
      F7_FADD_D:  fp_op = OP_FADD_D;
      F7_FSUB_S:  fp_op = OP_FSUB_S;
      F7_FSUB_D:  fp_op = OP_FSUB_D;
      F7_FMUL_S:  fp_op = OP_FMUL_S;
      F7_FMUL_D:  fp_op = OP_FMUL_D;
      F7_FDIV_S:  fp_op = OP_FDIV_S;
      F7_FDIV_D:  fp_op = OP_FDIV_D;
      F7_FSQRT_S: fp_op = OP_FSQRT_S;
      F7_FSQRT_D: fp_op = OP_FSQRT_D;
      F7_FCVT_IS: if (rs2[4:2] == 3'd0) fp_op = OP_FCVT_W_S + {5'd0, rs2[1:0]};
      F7_FCVT_ID: if (rs2[4:2] == 3'd0) fp_op = OP_FCVT_W_D + {5'd0, rs2[1:0]};
      F7_FCVT_SI: if (rs2[4:2] == 3'd0) fp_op = OP_FCVT_S_W + {5'd0, rs2[1:0]};
      F7_FCVT_DI: if (rs2[4:2] == 3'd0) fp_op = OP_FCVT_D_W + {5'd0, rs2[1:0]};
      F7_FSGNJ_S: if (f3 < 3'd3) fp_op = OP_FSGNJ_S + {4'd0, f3};
      F7_FSGNJ_D: if (f3 < 3'd3) fp_op = OP_FSGNJ_D + {4'd0, f3};
      F7_FMINMAX_S: if (f3 < 3'd2) fp_op = OP_FMIN_S + {4'd0, f3};
      F7_FMINMAX_D: if (f3 < 3'd2) fp_op = OP_FMIN_D + {4'd0, f3};
      F7_FCMP_S: begin
        unique case (f3)
          F3_FEQ:  fp_op = OP_FEQ_S;
          F3_FLT:  fp_op = OP_FLT_S;
          F3_FLE:  fp_op = OP_FLE_S;
          default: fp_op = OP_NONE;
        endcase
      end
      F7_FCMP_D: begin
        unique case (f3)
          F3_FEQ:  fp_op = OP_FEQ_D;
          F3_FLT:  fp_op = OP_FLT_D;
          F3_FLE:  fp_op = OP_FLE_D;
          default: fp_op = OP_NONE;
        endcase
      end
      F7_FMV_WX: fp_op = OP_FMV_W_X;
      F7_FMV_DX: fp_op = OP_FMV_D_X;
      F7_FMV_XW: begin
        if (f3 == F3_FMV)         fp_op = OP_FMV_X_W;
        else if (f3 == F3_FCLASS) fp_op = OP_FCLASS_S;
      end
      F7_FMV_XD: begin
        if (f3 == F3_FMV)         fp_op = OP_FMV_X_D;
        else if (f3 == F3_FCLASS) fp_op = OP_FCLASS_D;
      end
      F7_FCVT_DS: if (rs2 == RS2_FROM_S) fp_op = OP_FCVT_D_S;
      F7_FCVT_SD: if (rs2 == RS2_FROM_D) fp_op = OP_FCVT_S_D;
      default:   fp_op = OP_NONE;
    endcase
  end

  always_comb begin
    ctrl_o = '0;
    ctrl_o.alu_class     = CLASS_ADD;
    ctrl_o.alu_operation = OP_NONE;
    unique case (opc)
      OPC_LOAD, OPC_FLOAD: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.mem_to_reg    = 1'b1;
        ctrl_o.mem_read      = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      OPC_STORE, OPC_FSTORE: begin
        ctrl_o.mem_write     = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      OPC_FMADD, OPC_FMSUB, OPC_FNMSUB, OPC_FNMADD: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.alu_operation = fma_op;
      end
      OPC_OPFP: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.alu_operation = fp_op;
      end
      OPC_LUI: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      OPC_AUIPC: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.pc_operand    = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      OPC_OPIMM: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        if (f3 == F3_SRL) ctrl_o.alu_operation = alt ? OP_SRA : OP_SRL;
        else              ctrl_o.alu_operation = int_op(f3);
      end
      OPC_OP, OPC_OP32: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.alu_class     = CLASS_REG;
        ctrl_o.alu_operation = reg_op;
      end
      OPC_BRANCH: begin
        ctrl_o.is_branch     = 1'b1;
        ctrl_o.alu_class     = CLASS_BRANCH;
        // Branch funct3 codes 2 and 3 are reserved.
        ctrl_o.alu_operation = (f3[2:1] == 2'b01) ? OP_NONE : OP_SUB;
      end
      OPC_JAL: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.is_jump       = 1'b1;
        ctrl_o.pc_operand    = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      OPC_JALR: begin
        ctrl_o.reg_write     = 1'b1;
        ctrl_o.is_jump       = 1'b1;
        ctrl_o.alu_imm_src   = 1'b1;
        ctrl_o.alu_operation = OP_ADD;
      end
      default: ctrl_o = '0;
    endcase
  end

endmodule

/* rtl/riscv_instruction_control_decode_top.sv */
// RV64IMFD control decoder. Each accepted instruction word yields one result word with
// the main-control flags, the ALU class and a densely numbered ALU operation (0 for most
// unrecognized encodings; a fused multiply-add with fmt 2 or 3 yields OP_ADD). The block
// holds no architectural state. An instruction passes an input register and then a result
// register before its result is offered, and waits in the input register while the result
// register holds a result not yet taken. A new word is taken in every cycle as long as the
// output side takes results; the only limit on throughput is the consumer's ready.
module riscv_instruction_control_decode_top
  import rvcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] instruction_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        reg_write_o,
  output logic        mem_to_reg_o,
  output logic        is_branch_o,
  output logic        mem_read_o,
  output logic        mem_write_o,
  output logic        alu_imm_src_o,
  output logic        is_jump_o,
  output logic        pc_operand_o,
  output logic [1:0]  alu_class_o,
  output logic [6:0]  alu_operation_o
);

  logic [31:0] ins_q;
  logic        ins_valid_q, ins_valid_d;
  ctrl_t       res_q, res_d;
  logic        res_valid_q, res_valid_d;
  logic        res_free;
  logic        advance;
  logic        in_fire;

  // The result register can take a new word when it is empty or being drained.
  assign res_free   = !res_valid_q || out_ready_i;
  assign advance    = ins_valid_q && res_free;
  assign in_ready_o = !ins_valid_q || res_free;
  assign in_fire    = in_valid_i && in_ready_o;

  rvcd_decode u_decode (
    .instruction_i (ins_q),
    .ctrl_o        (res_d)
  );

  always_comb begin
    ins_valid_d = ins_valid_q;
    if (in_fire)      ins_valid_d = 1'b1;
    else if (advance) ins_valid_d = 1'b0;

    res_valid_d = res_valid_q;
    if (advance)          res_valid_d = 1'b1;
    else if (out_ready_i) res_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      ins_valid_q <= ins_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) ins_q <= instruction_i;
    if (advance) res_q <= res_d;
  end

  assign out_valid_o     = res_valid_q;
  assign reg_write_o     = res_q.reg_write;
  assign mem_to_reg_o    = res_q.mem_to_reg;
  assign is_branch_o     = res_q.is_branch;
  assign mem_read_o      = res_q.mem_read;
  assign mem_write_o     = res_q.mem_write;
  assign alu_imm_src_o   = res_q.alu_imm_src;
  assign is_jump_o       = res_q.is_jump;
  assign pc_operand_o    = res_q.pc_operand;
  assign alu_class_o     = res_q.alu_class;
  assign alu_operation_o = res_q.alu_operation;

endmodule
